/* design/wce_pkg.sv */
// Shared constants for the wavelet coding encoder.
// Holds parameter defaults, register and result widths, and saturation limits.
// No dependencies.
package wce_pkg;

    localparam int M_DEFAULT            = 2;
    localparam int G_DEFAULT            = 2;
    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int COEF_WIDTH_DEFAULT   = 4;

    localparam int CFG_WIDTH = 32;
    localparam int OUT_WIDTH = 24;
    localparam int OUT_MAX   = (2 ** (OUT_WIDTH - 1)) - 1;
    localparam int OUT_MIN   = -(2 ** (OUT_WIDTH - 1));

endpackage

/* design/wavelet_coding_encoder_unit.sv */
// Wavelet coding encoder top level with its result queue; depends on wce_pkg.
// Results of a block-completing request are registered into the result queue and reach the
// output once the results already queued ahead of them have drained.
// Throughput: one request per cycle; a block of M requests yields M results, stream-last M*G,
// drained one per cycle if m_ready is high from a 2*M*G queue holding s_ready low on overflow.
// Reset (aresetn low, synchronous): clears accumulators, block position, queue and coefficients.
module wavelet_coding_encoder_unit #(
    parameter int M            = wce_pkg::M_DEFAULT,
    parameter int G            = wce_pkg::G_DEFAULT,
    parameter int SAMPLE_WIDTH = wce_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int COEF_WIDTH   = wce_pkg::COEF_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wce_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_sample,
    input  logic                                 s_stream_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [wce_pkg::OUT_WIDTH-1:0] m_encoded_value,
    output logic                                 m_run_last
);

    localparam int BANDS   = M * G;
    localparam int ENTRIES = M * BANDS;
    localparam int QDEPTH  = 2 * BANDS;
    localparam int CNT_W   = $clog2(QDEPTH + 1);
    localparam int POS_W   = $clog2(M);
    localparam int OUT_W   = wce_pkg::OUT_WIDTH;
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int SUM_W   = ((PROD_W > OUT_W) ? PROD_W : OUT_W) + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(wce_pkg::OUT_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(wce_pkg::OUT_MIN);

    logic [wce_pkg::CFG_WIDTH-1:0] cfg_reg;
    logic signed [OUT_W-1:0]       acc_reg [BANDS];
    logic signed [OUT_W-1:0]       acc_next [BANDS];
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic signed [OUT_W-1:0]       q_val_reg [QDEPTH];
    logic signed [OUT_W-1:0]       q_val_next [QDEPTH];
    logic                          q_last_reg [QDEPTH];
    logic                          q_last_next [QDEPTH];

    logic signed [COEF_WIDTH-1:0]  coef_all [ENTRIES];
    logic signed [COEF_WIDTH-1:0]  coef_sel [BANDS];
    logic signed [PROD_W-1:0]      prod [BANDS];
    logic signed [SUM_W-1:0]       sum [BANDS];
    logic signed [OUT_W-1:0]       upd [BANDS];

    logic                          pos_last;
    logic                          complete;
    logic [CNT_W-1:0]              n_new;
    logic [CNT_W-1:0]              base;
    logic                          s_accept;
    logic                          pop;
    logic                          push;

    for (genvar e = 0; e < ENTRIES; e++) begin : g_coef
        if ((e + 1) * COEF_WIDTH <= wce_pkg::CFG_WIDTH) begin : g_in
            assign coef_all[e] = $signed(cfg_reg[e*COEF_WIDTH +: COEF_WIDTH]);
        end else begin : g_out
            assign coef_all[e] = '0;
        end
    end

    assign cfg_ready = 1'b1;
    assign pos_last  = (pos_reg == POS_W'(M - 1));
    assign complete  = pos_last || s_stream_last;
    assign n_new     = !complete ? '0 : (s_stream_last ? CNT_W'(BANDS) : CNT_W'(M));
    assign s_ready   = ({1'b0, count_reg} + {1'b0, n_new}) <= (CNT_W + 1)'(QDEPTH);
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = (count_reg != '0);
    assign pop       = m_valid && m_ready;
    assign push      = s_accept && (n_new != '0);
    assign base      = count_reg - CNT_W'(pop);

    assign m_encoded_value = q_val_reg[0];
    assign m_run_last      = q_last_reg[0];

    always_comb begin
        for (int j = 0; j < BANDS; j++) begin
            coef_sel[j] = '0;
            for (int p = 0; p < M; p++) begin
                if (pos_reg == POS_W'(p)) begin
                    coef_sel[j] = coef_all[p*BANDS + j];
                end
            end
            prod[j] = s_sample * coef_sel[j];
            sum[j]  = SUM_W'(acc_reg[j]) + SUM_W'(prod[j]);
            if (sum[j] > SUM_MAX) begin
                upd[j] = SUM_MAX[OUT_W-1:0];
            end else if (sum[j] < SUM_MIN) begin
                upd[j] = SUM_MIN[OUT_W-1:0];
            end else begin
                upd[j] = sum[j][OUT_W-1:0];
            end
        end
    end

    always_comb begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (s_accept) begin
            if (!complete) begin
                acc_next = upd;
                pos_next = pos_reg + POS_W'(1);
            end else begin
                for (int j = 0; j < BANDS; j++) begin
                    acc_next[j] = '0;
                end
                if (!s_stream_last) begin
                    for (int j = 0; j < BANDS - M; j++) begin
                        acc_next[j] = upd[j + M];
                    end
                end
                pos_next = '0;
            end
        end
    end

    always_comb begin
        q_val_next  = q_val_reg;
        q_last_next = q_last_reg;
        if (pop) begin
            for (int i = 0; i < QDEPTH - 1; i++) begin
                q_val_next[i]  = q_val_reg[i + 1];
                q_last_next[i] = q_last_reg[i + 1];
            end
        end
        if (push) begin
            for (int i = 0; i < QDEPTH; i++) begin
                for (int k = 0; k < BANDS; k++) begin
                    if ((CNT_W'(k) < n_new) && ((base + CNT_W'(k)) == CNT_W'(i))) begin
                        q_val_next[i]  = upd[k];
                        q_last_next[i] = (CNT_W'(k) == (n_new - CNT_W'(1)));
                    end
                end
            end
        end
        count_next = base + (push ? n_new : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg   <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            for (int j = 0; j < BANDS; j++) begin
                acc_reg[j] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end
            pos_reg   <= pos_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_val_reg  <= q_val_next;
        q_last_reg <= q_last_next;
    end

endmodule

/* design/wce_checker.sv */
// Port-level checks for the wavelet coding encoder, bound to its top level.
// Depends on wce_pkg and wavelet_coding_encoder_unit.
module wce_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 s_stream_last,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [wce_pkg::OUT_WIDTH-1:0] m_encoded_value,
    input logic                                 m_run_last
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("results pending after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_encoded_value) && $stable(m_run_last))
        else $error("stalled result changed");

    a_last_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_stream_last |=> m_valid)
        else $error("stream end produced no result");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request refused with empty result queue");

endmodule

bind wavelet_coding_encoder_unit wce_checker u_wce_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_stream_last(s_stream_last),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_encoded_value(m_encoded_value),
    .m_run_last(m_run_last)
);
